FILE: rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

    localparam int unsigned KEY_W        = 32;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned CAP_W        = 5;
    localparam int unsigned MAX_ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request operation codes
    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_op_t;

    // Broadcast from the control path to every entry
    typedef struct packed {
        logic do_touch;   // hit: promote the matching entry
        logic do_insert;  // put miss: evict, age and insert
        logic write_val;  // put hit: overwrite the value
    } entry_ctl_t;

    // Status returned by each entry
    typedef struct packed {
        logic match;
        logic keep;       // valid and survives eviction
    } entry_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/lkvc_entry.sv
// One cache entry: key/value storage, recency rank, match and update.
`default_nettype none
module lkvc_entry #(
    parameter int unsigned RANK_W = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    upd_en,
    input  wire lkvc_pkg::entry_ctl_t    ctl,
    input  wire logic [lkvc_pkg::KEY_W-1:0] key,
    input  wire logic [lkvc_pkg::VAL_W-1:0] value,
    input  wire logic [RANK_W-1:0]       hit_rank,
    input  wire logic [RANK_W-1:0]       evict_thr,
    input  wire logic                    slot_sel,
    output lkvc_pkg::entry_stat_t        stat,
    output logic [RANK_W-1:0]            rank,
    output logic [lkvc_pkg::VAL_W-1:0]   stored_value
);
    import lkvc_pkg::*;

    logic              valid_reg, valid_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic              match;
    logic              keep;

    // Compare the request key and check survival against the eviction threshold
    assign match = valid_reg && (key_reg == key);
    assign keep  = valid_reg && (rank_reg < evict_thr);

    assign stat         = '{match: match, keep: keep};
    assign rank         = rank_reg;
    assign stored_value = value_reg;

    // Work out the next entry contents for this request
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctl.do_touch)
        begin
            if (match)
            begin
                rank_next = '0;
                if (ctl.write_val)
                begin
                    value_next = value;
                end
            end
            else if (valid_reg && (rank_reg < hit_rank))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
        else if (ctl.do_insert)
        begin
            if (slot_sel)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
                key_next   = key;
                value_next = value;
            end
            else if (keep)
            begin
                rank_next = rank_reg + 1'b1;
            end
            else
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
        end
    end

    // Hold valid and rank under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (upd_en)
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Store key and value
    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            key_reg   <= key_next;
            value_reg <= value_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/lru_key_value_cache_core.sv
// Top level of the LRU key-value cache: request register, entry array, result register.
// A request moves on from the request register to the result register when the latter can take it.
// Throughput: one request per cycle unless out_ready stalls the result register; the match
// over all entries and the rank update are combinational between the two registers.
// Reset: asynchronous, active low; clears all entries, ranks and pipeline valids and
// sets the capacity to sixteen. No clearing pass is needed.
`default_nettype none
module lru_key_value_cache_core #(
    parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lkvc_pkg::CAP_W-1:0]    capacity_in_use,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0] lookup_key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0] put_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic signed [lkvc_pkg::VAL_W-1:0]  read_value
);
    import lkvc_pkg::*;

    localparam int unsigned RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CMP_W  = 8;

    logic [CAP_W-1:0]  cap_reg;
    logic              req_vld_reg, req_vld_next;
    cmd_op_t           req_cmd_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [VAL_W-1:0]  req_val_reg;
    logic              res_vld_reg, res_vld_next;
    logic              res_found_reg, res_found_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;

    logic              advance;
    logic              go;
    logic              in_take;
    entry_ctl_t        ctl;
    logic [RANK_W-1:0] hit_rank;
    logic [RANK_W-1:0] evict_thr;
    logic [VAL_W-1:0]  hit_value;
    logic              hit;

    entry_stat_t          stat_arr [MAX_ENTRIES];
    logic [RANK_W-1:0]    rank_arr [MAX_ENTRIES];
    logic [VAL_W-1:0]     value_arr [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic [MAX_ENTRIES-1:0] slot_vec;

    // Handshake: the request stage moves when the result register can take it
    assign advance  = !res_vld_reg || out_ready;
    assign in_ready = !req_vld_reg || advance;
    assign in_take  = in_valid && in_ready;
    assign go       = req_vld_reg && advance;

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= capacity_in_use;
        end
    end

    // Clamp the capacity to 1..MAX_ENTRIES and take one off for the rank threshold
    always_comb
    begin
        if (cap_reg == '0)
        begin
            evict_thr = '0;
        end
        else if (CMP_W'(cap_reg) >= CMP_W'(MAX_ENTRIES))
        begin
            evict_thr = RANK_W'(MAX_ENTRIES - 1);
        end
        else
        begin
            evict_thr = RANK_W'(cap_reg - 1'b1);
        end
    end

    // Request register
    assign req_vld_next = in_take ? 1'b1 : (advance ? 1'b0 : req_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_cmd_reg <= cmd_op_t'(cmd);
            req_key_reg <= lookup_key;
            req_val_reg <= put_value;
        end
    end

    // Gather match, hit rank and hit value over all entries
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            match_vec[i] = stat_arr[i].match;
            free_vec[i]  = !stat_arr[i].keep;
            if (stat_arr[i].match)
            begin
                hit_rank  = hit_rank | rank_arr[i];
                hit_value = hit_value | value_arr[i];
            end
        end
    end

    assign hit = |match_vec;

    // Pick the lowest free slot after eviction
    assign slot_vec = free_vec & (~free_vec + 1'b1);

    // Decode the request into entry controls
    always_comb
    begin
        ctl.do_touch  = hit;
        ctl.do_insert = !hit && (req_cmd_reg == CMD_PUT);
        ctl.write_val = req_cmd_reg == CMD_PUT;
    end

    // Entry array
    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_entry
        lkvc_entry #(
            .RANK_W(RANK_W)
        ) u_entry (
            .clk         (clk),
            .rst_n       (rst_n),
            .upd_en      (go),
            .ctl         (ctl),
            .key         (req_key_reg),
            .value       (req_val_reg),
            .hit_rank    (hit_rank),
            .evict_thr   (evict_thr),
            .slot_sel    (slot_vec[g]),
            .stat        (stat_arr[g]),
            .rank        (rank_arr[g]),
            .stored_value(value_arr[g])
        );
    end

    // Result register
    assign res_vld_next   = go ? 1'b1 : (out_ready ? 1'b0 : res_vld_reg);
    assign res_found_next = hit;
    assign res_val_next   = (hit && (req_cmd_reg == CMD_GET)) ? hit_value : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_found_reg <= res_found_next;
            res_val_reg   <= res_val_next;
        end
    end

    assign out_valid  = res_vld_reg;
    assign found      = res_found_reg;
    assign read_value = res_val_reg;

    // Keys stay unique among valid entries
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        req_vld_reg |-> $onehot0(match_vec))
        else $error("more than one entry matches the request key");

    // An insert always finds exactly one free slot
    a_insert_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (go && ctl.do_insert) |-> $onehot(slot_vec))
        else $error("insert without a single free slot");

    // A miss returns a zero value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (read_value == '0))
        else $error("miss result carries a non-zero value");

    // An empty result register never blocks a request
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_vld_reg |-> in_ready)
        else $error("request blocked while result register is empty");

endmodule
`default_nettype wire

FILE: test/tb_lru_key_value_cache_core.sv
// Self-checking testbench for the LRU key-value cache core, with its own cache predictor.
`default_nettype none
module tb_lru_key_value_cache_core;
    import lkvc_pkg::*;

    localparam int unsigned SLOTS       = MAX_ENTRIES_DEF;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE      = 10;
    localparam int unsigned MAX_SHOWN   = 10;

    typedef struct {
        logic              found;
        logic [VAL_W-1:0]  read_value;
    } reply_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CAP_W-1:0]         capacity_in_use;
    logic                     in_valid;
    logic                     in_ready;
    logic                     cmd;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [VAL_W-1:0]  put_value;
    logic                     out_valid;
    logic                     out_ready;
    logic                     found;
    logic signed [VAL_W-1:0]  read_value;

    // Predicted cache contents
    logic                     slot_valid [SLOTS];
    logic [KEY_W-1:0]         slot_key [SLOTS];
    logic [VAL_W-1:0]         slot_value [SLOTS];
    int unsigned              slot_rank [SLOTS];
    int unsigned              slot_count;
    logic [CAP_W-1:0]         cur_capacity;

    reply_t                   pending_replies [$];
    reply_t                   oldest_reply;
    int unsigned              requests_sent;
    int unsigned              replies_checked;
    int unsigned              hits_seen;
    int unsigned              mismatches;
    int unsigned              cycle_count;
    int unsigned              capacity_writes;
    bit                       no_idle;

    lru_key_value_cache_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .capacity_in_use (capacity_in_use),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cmd             (cmd),
        .lookup_key      (lookup_key),
        .put_value       (put_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .read_value      (read_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Promote one slot to most recent; more recent slots age by one
    function automatic void promote_slot(int idx);
        int unsigned r;
        r = slot_rank[idx];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i] && slot_rank[i] < r)
                slot_rank[i]++;
        end
        slot_rank[idx] = 0;
    endfunction

    // Apply one get or put to the predicted cache and return its reply
    function automatic reply_t lru_access(cmd_op_t op, logic [KEY_W-1:0] key,
                                          logic [VAL_W-1:0] val);
        reply_t      rep;
        int          hit;
        int          free_slot;
        int unsigned limit;
        hit       = -1;
        free_slot = -1;
        limit     = (cur_capacity == 0) ? 1 : ((cur_capacity > SLOTS) ? SLOTS : cur_capacity);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (hit < 0 && slot_valid[i] && slot_key[i] == key)
                hit = i;
        end
        rep.found      = (hit >= 0);
        rep.read_value = '0;
        if (hit >= 0)
        begin
            if (op == CMD_GET)
                rep.read_value = slot_value[hit];
            else
                slot_value[hit] = val;
            promote_slot(hit);
        end
        else if (op == CMD_PUT)
        begin
            // Evict everything that would not fit beside the new key
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_valid[i] && slot_rank[i] >= limit - 1)
                begin
                    slot_valid[i] = 1'b0;
                    slot_rank[i]  = 0;
                    if (slot_count > 0)
                        slot_count--;
                end
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                if (slot_valid[i])
                    slot_rank[i]++;
                else if (free_slot < 0)
                    free_slot = i;
            end
            if (free_slot >= 0)
            begin
                slot_valid[free_slot] = 1'b1;
                slot_key[free_slot]   = key;
                slot_value[free_slot] = val;
                slot_rank[free_slot]  = 0;
                slot_count++;
            end
        end
        return rep;
    endfunction

    function automatic int unsigned draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Send one request; returns at the edge where it is accepted
    task automatic send_request(cmd_op_t op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        lookup_key <= key;
        put_value  <= val;
        do
            @(posedge clk);
        while (!in_ready);
        pending_replies.push_back(lru_access(op, key, val));
        requests_sent++;
    endtask

    // Hold off new requests until every outstanding reply has arrived
    task automatic drain_replies();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        drain_replies();
        @(negedge clk);
        cfg_wr_en       <= 1'b1;
        capacity_in_use <= cap;
        @(negedge clk);
        cfg_wr_en       <= 1'b0;
        cur_capacity = cap;
        capacity_writes++;
        @(posedge clk);
    endtask

    task automatic test_miss_on_empty();
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_put_get_extremes();
        send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h0000_0000, 32'h5555_5555);
        send_request(CMD_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    endtask

    task automatic test_overwrite();
        send_request(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'h0000_0005, 32'h0000_0000);
    endtask

    // Capacity one, lowered below the current count: a new put flushes the rest
    task automatic test_capacity_one();
        set_capacity(5'd1);
        send_request(CMD_PUT, 32'h0000_0001, 32'hAAAA_AAAA);
        send_request(CMD_PUT, 32'h0000_0002, 32'h5555_5555);
        send_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
        send_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);
    endtask

    task automatic test_capacity_zero();
        set_capacity(5'd0);
        send_request(CMD_PUT, 32'h0000_0003, 32'h0000_0001);
        send_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);
        send_request(CMD_GET, 32'h0000_0003, 32'h0000_0000);
    endtask

    task automatic test_capacity_lowering();
        set_capacity(5'd16);
        send_request(CMD_PUT, 32'h0000_0010, 32'h0000_1010);
        send_request(CMD_PUT, 32'h0000_0011, 32'h0000_1111);
        send_request(CMD_PUT, 32'h0000_0012, 32'h0000_1212);
        set_capacity(5'd2);
        send_request(CMD_GET, 32'h0000_0010, 32'h0000_0000);
        send_request(CMD_PUT, 32'h0000_0013, 32'h0000_1313);
        send_request(CMD_GET, 32'h0000_0012, 32'h0000_0000);
    endtask

    // Random gets and puts over a working set sized around the capacity
    task automatic test_random_traffic(logic [CAP_W-1:0] cap, int unsigned count, bit steady);
        logic [KEY_W-1:0] key_pool [$];
        logic [KEY_W-1:0] key;
        int unsigned      limit;
        int unsigned      pool_size;
        cmd_op_t          op;
        set_capacity(cap);
        no_idle   = steady;
        limit     = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
        pool_size = limit + $urandom_range(1, limit + 2);
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back($urandom);
        for (int i = 0; i < count; i++)
        begin
            op  = ($urandom_range(0, 1) == 0) ? CMD_GET : CMD_PUT;
            key = ($urandom_range(0, 9) != 0) ? key_pool[$urandom_range(0, pool_size - 1)]
                                              : $urandom;
            send_request(op, key, $urandom);
            if (i == count / 2)
                drain_replies();
        end
        drain_replies();
        no_idle = 1'b0;
    endtask

    // Sink: draw a stall for every reply
    initial
    begin : reply_sink
        int unsigned stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // Compare every accepted reply with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected reply: found=%0b read_value=%h", found, read_value);
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                replies_checked++;
                if (oldest_reply.found)
                    hits_seen++;
                if (found !== oldest_reply.found || read_value !== oldest_reply.read_value)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("reply %0d mismatch: found exp %0b got %0b, read_value exp %h got %h",
                                 replies_checked, oldest_reply.found, found,
                                 oldest_reply.read_value, read_value);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        capacity_in_use = CAP_RESET;
        in_valid        = 1'b0;
        cmd             = CMD_GET;
        lookup_key      = '0;
        put_value       = '0;
        requests_sent   = 0;
        replies_checked = 0;
        hits_seen       = 0;
        mismatches      = 0;
        cycle_count     = 0;
        capacity_writes = 0;
        no_idle         = 1'b0;
        cur_capacity    = CAP_RESET;
        slot_count      = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_miss_on_empty();
        test_put_get_extremes();
        test_overwrite();
        test_capacity_one();
        test_capacity_zero();
        test_capacity_lowering();

        test_random_traffic(5'd16, 125, 1'b0);
        test_random_traffic(5'd1,  125, 1'b0);
        test_random_traffic(5'd5,  125, 1'b0);
        test_random_traffic(5'd0,  125, 1'b0);
        test_random_traffic(5'd31, 125, 1'b1);
        test_random_traffic(5'd3,  125, 1'b0);
        test_random_traffic(5'd12, 125, 1'b0);
        test_random_traffic(5'd2,  125, 1'b1);
        test_random_traffic(5'd16, 125, 1'b0);
        test_random_traffic(5'd7,  125, 1'b0);

        drain_replies();
        $display("Covered %0d gets and puts over %0d capacity settings (zero and above sixteen too).",
                 requests_sent, capacity_writes);
        $display("Checked %0d replies, %0d of them hits; %0d mismatches.",
                 replies_checked, hits_seen, mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_entry.sv
rtl/core/lru_key_value_cache_core.sv
test/tb_lru_key_value_cache_core.sv
